@@ design/vss_pkg.sv @@
// Package for the vector similarity score block: defaults, field widths,
// metric codes and the command/status structs between controller and datapath.
// No dependencies.
package vss_pkg;

	localparam int ELEMENT_WIDTH_DEF = 16;
	localparam int ACCUM_WIDTH_DEF   = 48;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int ELEM_FIELD_W  = 16;
	localparam int SCORE_W       = 64;
	localparam int MODE_W        = 2;

	localparam logic [MODE_W-1:0] MODE_COSINE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_L2     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INNER  = 2'd2;

	// Half-width of the square-root radicand (also the root width).
	function automatic int vss_root_half(input int aw, input int fb);
		int a;
		int b;
		a = aw - 1;
		b = (aw - 1 + 2 * fb + 1) / 2;
		return (a > b) ? a : b;
	endfunction

	typedef struct packed {
		logic       clear;
		logic       mul_first;
		logic       mul_issue;
		logic       mul_add;
		logic [1:0] mul_sel;
		logic       root_load_l2;
		logic       root_load_cos;
		logic       root_step;
		logic       div_init;
		logic       div_step;
		logic       out_load;
	} vss_cmd_t;

	typedef struct packed {
		logic is_l2;
		logic is_inner;
		logic cos_zero;
	} vss_stat_t;

endpackage

@@ design/vss_elem_if.sv @@
// Element-pair channel: valid/ready handshake plus one query/candidate pair.
// Depends on vss_pkg.
interface vss_elem_if import vss_pkg::*; ();
	logic                           valid;
	logic                           ready;
	logic signed [ELEM_FIELD_W-1:0] query_element;
	logic signed [ELEM_FIELD_W-1:0] candidate_element;
	logic                           last_element;

	modport source (output valid, query_element, candidate_element, last_element,
		input ready);
	modport sink (input valid, query_element, candidate_element, last_element,
		output ready);
endinterface

@@ design/vss_score_if.sv @@
// Score channel: valid/ready handshake plus one score and its clamp flag.
// Depends on vss_pkg.
interface vss_score_if import vss_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] score;
	logic                      saturated;

	modport source (output valid, score, saturated, input ready);
	modport sink (input valid, score, saturated, output ready);
endinterface

@@ design/vector_similarity_score.sv @@
// Top level of the vector similarity score block: controller plus datapath.
// Depends on vss_pkg, vss_elem_if, vss_score_if, vss_ctrl, vss_datapath.
//
//  channel    dir  handshake            payload
//  elem       in   valid/ready          query_element, candidate_element, last_element
//  result     out  valid/ready          score (Q.FRACTION_BITS), saturated
//  cfg        in   cfg_we               cfg_wdata = metric_mode
//
// Elements transfer one per cycle while in_ready is high; each is multiplied
// in a product stage and added into the saturating sums the cycle after.
// After a last element the input stalls while the score is formed:
//  inner product: sums drain; L2: plus RHALF root steps (one root bit per cycle);
//  cosine: plus the norm product (four 32x32 partial products), root and divider.
//  RHALF = max(ACCUM_WIDTH-1, ceil((ACCUM_WIDTH-1+2*FRACTION_BITS)/2)).
// The score sits in an output register; sums clear when it is loaded, and if
// the previous score is still untaken the load waits for it.
// Reset clears the sums, the metric register (cosine) and all handshakes.
module vector_similarity_score import vss_pkg::*; #(
	parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
	parameter int ACCUM_WIDTH   = ACCUM_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	vss_elem_if.sink          elem,
	vss_score_if.source       result,
	input  logic              cfg_we,
	input  logic [MODE_W-1:0] cfg_wdata
);
	vss_cmd_t  cmd;
	vss_stat_t stat;
	logic      take;

	// a transfer on the element channel feeds the product stage
	assign take = elem.valid && elem.ready;

	vss_ctrl #(
		.ACCUM_WIDTH   (ACCUM_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (elem.valid),
		.in_last   (elem.last_element),
		.in_ready  (elem.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	vss_datapath #(
		.ELEMENT_WIDTH (ELEMENT_WIDTH),
		.ACCUM_WIDTH   (ACCUM_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.take              (take),
		.query_element     (elem.query_element),
		.candidate_element (elem.candidate_element),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.cmd               (cmd),
		.stat              (stat),
		.score             (result.score),
		.saturated         (result.saturated)
	);
endmodule

@@ design/vss_isqrt.sv @@
// Digit-by-digit integer square root, one result bit per step.
// Depends on vss_pkg only for house consistency (no types used).
module vss_isqrt import vss_pkg::*; #(
	parameter int RHALF = 63
) (
	input  logic               clk,
	input  logic               load,
	input  logic               step,
	input  logic [2*RHALF-1:0] radicand,
	output logic [RHALF-1:0]   root
);
	logic [2*RHALF-1:0] rad_q;
	logic [RHALF+1:0]   rem_q;
	logic [RHALF-1:0]   root_q;
	logic [RHALF+1:0]   rem_n;
	logic [RHALF+1:0]   trial;

	assign rem_n = {rem_q[RHALF-1:0], rad_q[2*RHALF-1:2*RHALF-2]};
	assign trial = {root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (load) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (step) begin
			rad_q <= rad_q << 2;
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[RHALF-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[RHALF-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule

@@ design/vss_datapath.sv @@
// Datapath: product stage, saturating sums, norm multiplier, shared square
// root, fraction divider and score register. Depends on vss_pkg, vss_isqrt.
module vss_datapath import vss_pkg::*; #(
	parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
	parameter int ACCUM_WIDTH   = ACCUM_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic [ELEM_FIELD_W-1:0]        query_element,
	input  logic [ELEM_FIELD_W-1:0]        candidate_element,
	input  logic                           cfg_we,
	input  logic [MODE_W-1:0]              cfg_wdata,
	input  vss_cmd_t                       cmd,
	output vss_stat_t                      stat,
	output logic signed [SCORE_W-1:0]      score,
	output logic                           saturated
);
	localparam int EW    = ELEMENT_WIDTH;
	localparam int AW    = ACCUM_WIDTH;
	localparam int FB    = FRACTION_BITS;
	localparam int PW    = 2 * EW + 2;
	localparam int SW    = ((AW > PW) ? AW : PW) + 1;
	localparam int RHALF = vss_root_half(AW, FB);
	localparam int DW    = ((AW > RHALF + 1) ? AW : RHALF + 1) + 1;
	localparam logic signed [SW-1:0] AMAX = {{(SW-AW+1){1'b0}}, {(AW-1){1'b1}}};
	localparam logic signed [SW-1:0] AMIN = {{(SW-AW+1){1'b1}}, {(AW-1){1'b0}}};
	localparam logic signed [SCORE_W-1:0] INNER_LIM = 64'sh7FFFFFFFFFFFFFFF >>> FB;
	localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

	function automatic logic signed [EW-1:0] ext_elem(input logic [ELEM_FIELD_W-1:0] v);
		logic [EW+ELEM_FIELD_W-1:0] t;
		t = {{EW{1'b0}}, v};
		return signed'(t[EW-1:0]);
	endfunction

	// returns {clamped, sum}
	function automatic logic [AW:0] sat_add(input logic signed [AW-1:0] a,
		input logic signed [PW-1:0] b);
		logic signed [SW-1:0] s;
		s = SW'(a) + SW'(b);
		if (s > AMAX)
			return {1'b1, AMAX[AW-1:0]};
		else if (s < AMIN)
			return {1'b1, AMIN[AW-1:0]};
		return {1'b0, s[AW-1:0]};
	endfunction

	logic [MODE_W-1:0] mode_q;

	logic signed [EW-1:0]   qa, cb;
	logic signed [EW:0]     df;
	logic signed [PW-1:0]   p_ab_s1, p_aa_s1, p_bb_s1, p_dd_s1;
	logic                   valid_s1;

	logic signed [AW-1:0]   dot_q, qn_q, cn_q, sd_q;
	logic                   sticky_q;
	logic [AW:0]            r_dot, r_qn, r_cn, r_sd;

	assign qa = ext_elem(query_element);
	assign cb = ext_elem(candidate_element);
	assign df = {qa[EW-1], qa} - {cb[EW-1], cb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_COSINE;
		end else begin
			valid_s1 <= take;
			if (cfg_we)
				mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			p_ab_s1 <= PW'(qa * cb);
			p_aa_s1 <= PW'(qa * qa);
			p_bb_s1 <= PW'(cb * cb);
			p_dd_s1 <= df * df;
		end
	end

	assign r_dot = sat_add(dot_q, p_ab_s1);
	assign r_qn  = sat_add(qn_q,  p_aa_s1);
	assign r_cn  = sat_add(cn_q,  p_bb_s1);
	assign r_sd  = sat_add(sd_q,  p_dd_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q    <= '0;
			qn_q     <= '0;
			cn_q     <= '0;
			sd_q     <= '0;
			sticky_q <= 1'b0;
		end else if (cmd.clear) begin
			dot_q    <= '0;
			qn_q     <= '0;
			cn_q     <= '0;
			sd_q     <= '0;
			sticky_q <= 1'b0;
		end else if (valid_s1) begin
			dot_q    <= signed'(r_dot[AW-1:0]);
			qn_q     <= signed'(r_qn[AW-1:0]);
			cn_q     <= signed'(r_cn[AW-1:0]);
			sd_q     <= signed'(r_sd[AW-1:0]);
			sticky_q <= sticky_q | r_dot[AW] | r_qn[AW] | r_cn[AW] | r_sd[AW];
		end
	end

	assign stat.is_l2    = (mode_q == MODE_L2);
	assign stat.is_inner = (mode_q == MODE_INNER);
	assign stat.cos_zero = (qn_q <= 0) || (cn_q <= 0);

	// norm product qn*cn over four 32x32 partial products
	logic [63:0]  qn64, cn64;
	logic [31:0]  mul_a, mul_b;
	logic [63:0]  pp_q;
	logic [1:0]   pp_sh_q;
	logic [127:0] prod_q;

	assign qn64  = 64'(unsigned'(qn_q));
	assign cn64  = 64'(unsigned'(cn_q));
	assign mul_a = cmd.mul_sel[1] ? qn64[63:32] : qn64[31:0];
	assign mul_b = cmd.mul_sel[0] ? cn64[63:32] : cn64[31:0];

	always_ff @(posedge clk) begin
		if (cmd.mul_issue) begin
			pp_q    <= mul_a * mul_b;
			pp_sh_q <= 2'(cmd.mul_sel[1]) + 2'(cmd.mul_sel[0]);
		end
		if (cmd.mul_first)
			prod_q <= '0;
		else if (cmd.mul_add)
			prod_q <= prod_q + (128'(pp_q) << (32 * pp_sh_q));
	end

	// shared square root
	logic [2*RHALF-1:0] radicand;
	logic [RHALF-1:0]   root;
	logic [2*RHALF-1:0] rad_l2;

	assign rad_l2   = (2*RHALF)'(unsigned'(sd_q[AW-2:0])) << (2 * FB);
	assign radicand = cmd.root_load_cos ? prod_q[2*RHALF-1:0] : rad_l2;

	vss_isqrt #(.RHALF(RHALF)) u_isqrt (
		.clk      (clk),
		.load     (cmd.root_load_l2 | cmd.root_load_cos),
		.step     (cmd.root_step),
		.radicand (radicand),
		.root     (root)
	);

	// fraction divider: |dot| * 2^FB / root
	logic [AW-1:0]    mag;
	logic [DW-1:0]    mag_w;
	logic             ge;
	logic [DW-1:0]    rem_init;
	logic [RHALF:0]   rem_q;
	logic [FB:0]      q_q;
	logic             over_q;
	logic [RHALF+1:0] r2;

	assign mag      = dot_q[AW-1] ? AW'(-dot_q) : unsigned'(dot_q);
	assign mag_w    = DW'(mag);
	assign ge       = mag_w >= DW'(root);
	assign rem_init = ge ? mag_w - DW'(root) : mag_w;
	assign r2       = {rem_q, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			over_q <= mag_w >= (DW'(root) << 1);
			rem_q  <= rem_init[RHALF:0];
			q_q    <= (FB+1)'(ge);
		end else if (cmd.div_step) begin
			if (r2 >= (RHALF+2)'(root)) begin
				rem_q <= (RHALF+1)'(r2 - (RHALF+2)'(root));
				q_q   <= {q_q[FB-1:0], 1'b1};
			end else begin
				rem_q <= r2[RHALF:0];
				q_q   <= {q_q[FB-1:0], 1'b0};
			end
		end
	end

	// score selection
	logic signed [SCORE_W-1:0] dot64;
	logic signed [SCORE_W-1:0] score_n;
	logic                      sat_n;
	logic [FB:0]               q_c;
	logic                      q_clamp;

	assign dot64   = SCORE_W'(dot_q);
	assign q_clamp = over_q || (q_q > ONE);
	assign q_c     = q_clamp ? ONE : q_q;

	always_comb begin
		score_n = '0;
		sat_n   = 1'b0;
		if (stat.is_l2) begin
			score_n = -signed'(SCORE_W'(root));
		end else if (stat.is_inner) begin
			if (dot64 > INNER_LIM) begin
				score_n = 64'sh7FFFFFFFFFFFFFFF;
				sat_n   = 1'b1;
			end else if (dot64 < ~INNER_LIM) begin
				score_n = 64'sh8000000000000000;
				sat_n   = 1'b1;
			end else begin
				score_n = dot64 <<< FB;
			end
		end else if (!stat.cos_zero) begin
			sat_n   = q_clamp;
			score_n = dot_q[AW-1] ? -signed'(SCORE_W'(q_c)) : signed'(SCORE_W'(q_c));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			score     <= score_n;
			saturated <= sat_n | sticky_q;
		end
	end
endmodule

@@ design/vss_ctrl.sv @@
// Controller: input handshake, finishing sequence and score valid flag.
// Depends on vss_pkg.
module vss_ctrl import vss_pkg::*; #(
	parameter int ACCUM_WIDTH   = ACCUM_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  vss_stat_t stat,
	output vss_cmd_t  cmd
);
	localparam int RHALF = vss_root_half(ACCUM_WIDTH, FRACTION_BITS);
	localparam int MAXC0 = (RHALF > FRACTION_BITS) ? RHALF : FRACTION_BITS;
	localparam int MAXC  = (MAXC0 > 6) ? MAXC0 : 6;
	localparam int CW    = $clog2(MAXC + 1);

	typedef enum logic [6:0] {
		S_ACCUM  = 7'b0000001,
		S_DRAIN  = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_MULT   = 7'b0001000,
		S_ROOT   = 7'b0010000,
		S_DIVSET = 7'b0100000,
		S_DIVIDE = 7'b1000000
	} vss_state_t;

	vss_state_t    state_q, state_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic          out_valid_q, out_valid_n;
	logic          finish_q, finish_n;
	logic          slot_free;

	assign in_ready  = (state_q == S_ACCUM) && !finish_q;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_n     = state_q;
		cnt_n       = cnt_q;
		finish_n    = finish_q;
		out_valid_n = out_valid_q && !out_ready;
		cmd         = '0;
		case (state_q)
			S_ACCUM: begin
				if (finish_q) begin
					if (slot_free) begin
						cmd.out_load = 1'b1;
						cmd.clear    = 1'b1;
						out_valid_n  = 1'b1;
						finish_n     = 1'b0;
					end
				end else if (in_valid && in_last) begin
					state_n = S_DRAIN;
				end
			end
			S_DRAIN: state_n = S_DECIDE;
			S_DECIDE: begin
				cnt_n = '0;
				if (stat.is_l2) begin
					cmd.root_load_l2 = 1'b1;
					state_n          = S_ROOT;
				end else if (stat.is_inner || stat.cos_zero) begin
					finish_n = 1'b1;
					state_n  = S_ACCUM;
				end else begin
					state_n = S_MULT;
				end
			end
			S_MULT: begin
				cmd.mul_sel   = cnt_q[1:0];
				cmd.mul_issue = (cnt_q < CW'(4));
				cmd.mul_first = (cnt_q == '0);
				cmd.mul_add   = (cnt_q != '0) && (cnt_q < CW'(5));
				cnt_n         = cnt_q + 1'b1;
				if (cnt_q == CW'(5)) begin
					cmd.root_load_cos = 1'b1;
					cnt_n             = '0;
					state_n           = S_ROOT;
				end
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				cnt_n         = cnt_q + 1'b1;
				if (cnt_q == CW'(RHALF - 1)) begin
					cnt_n = '0;
					if (stat.is_l2) begin
						finish_n = 1'b1;
						state_n  = S_ACCUM;
					end else begin
						state_n = S_DIVSET;
					end
				end
			end
			S_DIVSET: begin
				cmd.div_init = 1'b1;
				cnt_n        = '0;
				if (FRACTION_BITS == 0) begin
					finish_n = 1'b1;
					state_n  = S_ACCUM;
				end else begin
					state_n = S_DIVIDE;
				end
			end
			S_DIVIDE: begin
				cmd.div_step = 1'b1;
				cnt_n        = cnt_q + 1'b1;
				if (cnt_q == CW'(FRACTION_BITS - 1)) begin
					finish_n = 1'b1;
					state_n  = S_ACCUM;
				end
			end
			default: state_n = S_ACCUM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACCUM;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			finish_q    <= 1'b0;
		end else begin
			state_q     <= state_n;
			cnt_q       <= cnt_n;
			out_valid_q <= out_valid_n;
			finish_q    <= finish_n;
		end
	end
endmodule

@@ tb/vector_similarity_score_tb.sv @@
// Self-checking testbench for vector_similarity_score: drives element pairs,
// predicts each score and checks every result transfer against it.
// Depends on vss_pkg, vss_elem_if, vss_score_if and the block itself.
`timescale 1ns / 100ps

module vector_similarity_score_tb import vss_pkg::*; ();

	localparam int ELEM_W = ELEMENT_WIDTH_DEF;
	localparam int ACC_W  = ACCUM_WIDTH_DEF;
	localparam int FRAC_W = FRACTION_BITS_DEF;
	// spare metric code, decodes as cosine
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic signed [SCORE_W-1:0] score;
		logic                      saturated;
	} score_t;

	logic clk;
	logic arst_n;
	logic              cfg_we;
	logic [MODE_W-1:0] cfg_wdata;

	vss_elem_if  elem_ch ();
	vss_score_if score_ch ();

	vector_similarity_score dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.elem      (elem_ch),
		.result    (score_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state: the metric register and the four saturating sums
	logic [MODE_W-1:0]    pred_mode;
	logic signed [63:0]   dot_acc, qnorm_acc, cnorm_acc, sqdiff_acc;
	logic                 clamp_seen;
	score_t               pending_scores[$];

	int     fail_count;
	longint cycle_count;
	bit     send_idle_en;
	bit     recv_idle_en;
	int     recv_hold;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run-time guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// floor(sqrt(n)), one root bit at a time
	function automatic logic [63:0] root_floor(input logic [127:0] n);
		logic [127:0] r;
		logic [127:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= n)
				r = c;
		end
		return r[63:0];
	endfunction

	// add with clamp to the signed accumulator range; clamps are sticky
	function automatic logic signed [63:0] acc_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		logic signed [63:0] s;
		hi = (64'sd1 <<< (ACC_W - 1)) - 1;
		lo = -hi - 1;
		s = a + b;
		if (s > hi) begin
			clamp_seen = 1'b1;
			return hi;
		end
		if (s < lo) begin
			clamp_seen = 1'b1;
			return lo;
		end
		return s;
	endfunction

	function automatic void clear_sums();
		dot_acc = 0;
		qnorm_acc = 0;
		cnorm_acc = 0;
		sqdiff_acc = 0;
		clamp_seen = 1'b0;
	endfunction

	// fold one accepted pair in; on a last element queue the expected score
	function automatic void predict_pair(input logic [ELEM_FIELD_W-1:0] q_raw,
		input logic [ELEM_FIELD_W-1:0] c_raw, input logic last);
		logic signed [63:0] qa, ca, diff, sc;
		logic [127:0] wide, den, mag;
		logic [63:0] quo, one;
		logic sat;
		score_t exp_score;
		qa = 64'(signed'(q_raw[ELEM_W-1:0]));
		ca = 64'(signed'(c_raw[ELEM_W-1:0]));
		diff = qa - ca;
		dot_acc = acc_add(dot_acc, qa * ca);
		qnorm_acc = acc_add(qnorm_acc, qa * qa);
		cnorm_acc = acc_add(cnorm_acc, ca * ca);
		sqdiff_acc = acc_add(sqdiff_acc, diff * diff);
		if (!last)
			return;
		sat = 1'b0;
		one = 64'd1 << FRAC_W;
		if (pred_mode == MODE_L2) begin
			wide = (sqdiff_acc < 0) ? '0 : 128'(sqdiff_acc);
			sc = -$signed(root_floor(wide << (2 * FRAC_W)));
		end else if (pred_mode == MODE_INNER) begin
			// sums stay inside 48 bits, so the shifted product fits
			sc = dot_acc <<< FRAC_W;
		end else if (qnorm_acc <= 0 || cnorm_acc <= 0) begin
			sc = 0;   // zero norm
		end else begin
			den = 128'(root_floor(128'(qnorm_acc) * 128'(cnorm_acc)));
			mag = (dot_acc < 0) ? 128'(-dot_acc) : 128'(dot_acc);
			if (mag / den >= 2)
				quo = one + 1;
			else
				quo = 64'((mag << FRAC_W) / den);
			if (quo > one) begin
				sat = 1'b1;
				quo = one;
			end
			sc = (dot_acc < 0) ? -$signed(quo) : $signed(quo);
		end
		exp_score.score = sc;
		exp_score.saturated = sat | clamp_seen;
		pending_scores.push_back(exp_score);
		clear_sums();
	endfunction

	// one element-pair transfer, with an optional idle burst before it
	task automatic send_pair(input logic [ELEM_FIELD_W-1:0] q,
		input logic [ELEM_FIELD_W-1:0] c, input logic last);
		int gap;
		gap = (send_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
		if (gap > 0) begin
			elem_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		elem_ch.valid <= 1'b1;
		elem_ch.query_element <= q;
		elem_ch.candidate_element <= c;
		elem_ch.last_element <= last;
		do
			@(posedge clk);
		while (!elem_ch.ready);
		predict_pair(q, c, last);
	endtask

	// stop offering, let every score drain, then allow the datapath to settle
	task automatic wait_idle();
		elem_ch.valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		pred_mode = m;
	endtask

	// mostly full-scale or random, with the extremes well represented
	function automatic logic [ELEM_FIELD_W-1:0] pick_elem();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 7)) - 16'd3;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_vector(input int len);
		for (int i = 0; i < len; i++)
			send_pair(pick_elem(), pick_elem(), i == len - 1);
	endtask

	// field extremes, zero norms and exact-one cosine under every metric code
	task automatic test_directed();
		logic [MODE_W-1:0] modes[4];
		modes = '{MODE_COSINE, MODE_L2, MODE_INNER, MODE_SPARE};
		foreach (modes[k]) begin
			write_mode(modes[k]);
			send_pair(16'h7fff, 16'h7fff, 1'b1);
			send_pair(16'h8000, 16'h8000, 1'b1);
			send_pair(16'h8000, 16'h7fff, 1'b1);
			send_pair(16'h0000, 16'h1234, 1'b1);   // query norm zero
			send_pair(16'h0000, 16'h0000, 1'b1);   // both zero
		end
	endtask

	// long runs of maximum-difference and maximum-product pairs: sums grow well past 32 bits
	task automatic test_accum_clamp();
		write_mode(MODE_L2);
		for (int i = 0; i < 200; i++)
			send_pair(16'h7fff, 16'h8000, i == 199);
		write_mode(MODE_INNER);
		for (int i = 0; i < 200; i++)
			send_pair(16'h8000, 16'h8000, i == 199);
	endtask

	// receiver stalls for a long stretch while the sender keeps going
	task automatic test_backpressure();
		write_mode(MODE_COSINE);
		recv_hold = 400;
		repeat (30) send_vector($urandom_range(1, 3));
	endtask

	task automatic test_random();
		for (int p = 0; p < 8; p++) begin
			write_mode(MODE_W'($urandom_range(0, 3)));
			repeat (10) send_vector($urandom_range(1, 8));
		end
	endtask

	// final stretch with both sides always ready
	task automatic test_streaming();
		send_idle_en = 1'b0;
		recv_idle_en = 1'b0;
		write_mode(MODE_INNER);
		repeat (30) send_vector($urandom_range(1, 6));
		write_mode(MODE_COSINE);
		repeat (30) send_vector($urandom_range(1, 6));
	endtask

	// result side: random not-ready bursts, hold-off on request, and the check
	initial begin
		int burst;
		score_t exp_score;
		burst = 0;
		score_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (score_ch.valid && score_ch.ready) begin
				if (pending_scores.size() == 0) begin
					$error("unexpected score transfer: score %0d", score_ch.score);
					fail_count++;
				end else begin
					exp_score = pending_scores.pop_front();
					if (score_ch.score !== exp_score.score) begin
						$error("score: expected %0d, actual %0d", exp_score.score,
							score_ch.score);
						fail_count++;
					end
					if (score_ch.saturated !== exp_score.saturated) begin
						$error("saturated: expected %0b, actual %0b",
							exp_score.saturated, score_ch.saturated);
						fail_count++;
					end
				end
			end
			if (recv_hold > 0) begin
				recv_hold--;
				score_ch.ready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				score_ch.ready <= 1'b0;
			end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(0, 16);
				score_ch.ready <= 1'b0;
			end else begin
				score_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		fail_count = 0;
		cycle_count = 0;
		send_idle_en = 1'b1;
		recv_idle_en = 1'b1;
		recv_hold = 0;
		pred_mode = MODE_COSINE;
		clear_sums();
		elem_ch.valid = 1'b0;
		elem_ch.query_element = '0;
		elem_ch.candidate_element = '0;
		elem_ch.last_element = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_accum_clamp();
		test_backpressure();
		test_random();
		test_streaming();
		wait_idle();

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
design/vss_pkg.sv
design/vss_elem_if.sv
design/vss_score_if.sv
design/vss_isqrt.sv
design/vss_datapath.sv
design/vss_ctrl.sv
design/vector_similarity_score.sv
tb/vector_similarity_score_tb.sv
